[sv/itfss_pkg.sv]
// ----------------------------------------------------------------------------
// itfss_pkg
// Shared types and constants for the inductor track filter and steer select.
// ----------------------------------------------------------------------------
package itfss_pkg;

  localparam int HISTORY_DEPTH = 7;
  localparam int CHANNELS      = 5;
  localparam int PAST_TAPS     = HISTORY_DEPTH - 1;

  localparam int SAMPLE_W = 8;
  localparam int SUM_W    = $clog2(HISTORY_DEPTH * 255 + 1);

  // truncating divide by HISTORY_DEPTH as multiply by rounded-up reciprocal,
  // exact over the whole sum range
  localparam int DIV_SHIFT = SUM_W + 5;
  localparam int DIV_MUL   = ((1 << DIV_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
  localparam int PROD_W    = SUM_W + DIV_SHIFT;

  localparam int CH_VERT    = 0;
  localparam int CH_LEFT    = 1;
  localparam int CH_RIGHT   = 2;
  localparam int CH_LSLANT  = 3;
  localparam int CH_RSLANT  = 4;

  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] chan_vec_t;
  typedef logic [CHANNELS-1:0][SUM_W-1:0]    sum_vec_t;

  typedef struct packed {
    logic signed [7:0] steer_target;
    logic [8:0]        right_wheel_duty;
    logic [8:0]        left_wheel_duty;
    logic [1:0]        gain_prop;
    logic [7:0]        gain_deriv;
  } steer_t;

endpackage

[sv/itfss_in_if.sv]
// ----------------------------------------------------------------------------
// itfss_in_if
// Sample channel: one item carries the five raw inductor readings.
// ----------------------------------------------------------------------------
interface itfss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] vertical_sample;
  logic [7:0] left_level_sample;
  logic [7:0] right_level_sample;
  logic [7:0] left_slant_sample;
  logic [7:0] right_slant_sample;

  modport source (
    output valid, vertical_sample, left_level_sample, right_level_sample,
           left_slant_sample, right_slant_sample,
    input  ready
  );
  modport sink (
    input  valid, vertical_sample, left_level_sample, right_level_sample,
           left_slant_sample, right_slant_sample,
    output ready
  );
endinterface

[sv/itfss_out_if.sv]
// ----------------------------------------------------------------------------
// itfss_out_if
// Result channel: steering target, wheel duties, gains and filtered values.
// ----------------------------------------------------------------------------
interface itfss_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] steer_target;
  logic [8:0]        right_wheel_duty;
  logic [8:0]        left_wheel_duty;
  logic [1:0]        gain_prop;
  logic [7:0]        gain_deriv;
  logic [7:0]        filt_vertical;
  logic [7:0]        filt_left_level;
  logic [7:0]        filt_right_level;
  logic [7:0]        filt_left_slant;
  logic [7:0]        filt_right_slant;

  modport source (
    output valid, steer_target, right_wheel_duty, left_wheel_duty, gain_prop,
           gain_deriv, filt_vertical, filt_left_level, filt_right_level,
           filt_left_slant, filt_right_slant,
    input  ready
  );
  modport sink (
    input  valid, steer_target, right_wheel_duty, left_wheel_duty, gain_prop,
           gain_deriv, filt_vertical, filt_left_level, filt_right_level,
           filt_left_slant, filt_right_slant,
    output ready
  );
endinterface

[sv/itfss_tap_cell.sv]
// ----------------------------------------------------------------------------
// itfss_tap_cell
// One history tap for all channels: holds a past sample, passes it on when
// the chain shifts, and adds it to the running sum from its neighbor.
// ----------------------------------------------------------------------------
module itfss_tap_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  itfss_pkg::chan_vec_t din,
  input  itfss_pkg::sum_vec_t  sum_in,
  output itfss_pkg::chan_vec_t dout,
  output itfss_pkg::sum_vec_t  sum_out
);
  import itfss_pkg::*;

  chan_vec_t tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (shift) begin
      tap <= din;
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sum_out[c] = sum_in[c] + SUM_W'(tap[c]);
    end
  end

  assign dout = tap;

endmodule

[sv/itfss_select.sv]
// ----------------------------------------------------------------------------
// itfss_select
// Track case selection: straight, both high, left curve, right curve, crossing override.
// ----------------------------------------------------------------------------
module itfss_select (
  input  itfss_pkg::chan_vec_t filt,
  output itfss_pkg::steer_t    steer
);
  import itfss_pkg::*;

  function automatic logic [4:0] div10(input logic [7:0] x);
    logic [15:0] p;
    p = {8'd0, x} * 16'd205;
    return p[15:11];
  endfunction

  function automatic logic signed [9:0] div8_trunc(input logic signed [9:0] x);
    logic signed [9:0] t;
    t = x + (x[9] ? 10'sd7 : 10'sd0);
    return t >>> 3;
  endfunction

  logic [7:0]        v, l, r, sl, sr;
  logic [8:0]        lr_sum;
  logic signed [9:0] diff, dclamp, target;
  logic [8:0]        rduty, lduty;
  logic [1:0]        gp;
  logic [7:0]        gd;

  always_comb begin
    v      = filt[CH_VERT];
    l      = filt[CH_LEFT];
    r      = filt[CH_RIGHT];
    sl     = filt[CH_LSLANT];
    sr     = filt[CH_RSLANT];
    lr_sum = {1'b0, l} + {1'b0, r};
    diff   = $signed({2'b00, sl}) - $signed({2'b00, sr});
    target = 10'sd30 + div8_trunc(diff);
    rduty  = 9'd320;
    lduty  = 9'd320;
    gp     = 2'd3;
    gd     = 8'd250;

    if (l > 8'd110 && r > 8'd110) begin
      gp    = 2'd2;
      gd    = 8'd30;
      rduty = 9'd300;
      lduty = 9'd300;
    end else if (sr < 8'd50 && sl > sr) begin
      target = 10'sd75 - $signed({5'd0, div10(sl)});
      rduty  = 9'd270;
      if (sr < 8'd10 && lr_sum < 9'd150) rduty = 9'd240;
      if (sr < 8'd5 && lr_sum < 9'd150) rduty = 9'd220;
      lduty = rduty - 9'd50;
    end else if (sl < 8'd50 && sr > sl) begin
      target = $signed({5'd0, div10(sr)}) - 10'sd15;
      lduty  = 9'd270;
      if (sl < 8'd20 && lr_sum < 9'd130) lduty = 9'd240;
      if (sl < 8'd5 && lr_sum < 9'd130) lduty = 9'd220;
      rduty = lduty - 9'd50;
    end

    dclamp = diff;
    if (diff > 10'sd100) dclamp = 10'sd100;
    if (diff < -10'sd100) dclamp = -10'sd100;
    if (v > 8'd190) begin
      gp     = 2'd1;
      gd     = 8'd50;
      target = 10'sd30 + div8_trunc(dclamp);
    end

    steer.steer_target     = target[7:0];
    steer.right_wheel_duty = rduty;
    steer.left_wheel_duty  = lduty;
    steer.gain_prop        = gp;
    steer.gain_deriv       = gd;
  end

endmodule

[sv/inductor_track_filter_and_steer_select_unit.sv]
// ----------------------------------------------------------------------------
// inductor_track_filter_and_steer_select_unit
// Moving-average filter over five inductor channels and steering case select.
// ----------------------------------------------------------------------------
// Takes one sample item per clock and delivers one result item per sample.
// An accepted sample passes two pipeline registers: the tap-cell chain sum and
// reciprocal divide load the filter register, and case selection loads the
// output register. Throughput is one item per cycle while the result side is
// ready; a stalled result holds both pipeline registers and then input ready.
// History clears to zero on reset with no clearing pass.
module inductor_track_filter_and_steer_select_unit (
  input logic clk,
  input logic rst,
  itfss_in_if.sink    sample,
  itfss_out_if.source result
);
  import itfss_pkg::*;

  chan_vec_t raw;
  chan_vec_t cell_d   [PAST_TAPS+1];
  sum_vec_t  cell_sum [PAST_TAPS+1];
  chan_vec_t filt, filt_next;
  steer_t    steer;
  logic      s1_valid;
  logic      out_adv, take;

  assign raw[CH_VERT]   = sample.vertical_sample;
  assign raw[CH_LEFT]   = sample.left_level_sample;
  assign raw[CH_RIGHT]  = sample.right_level_sample;
  assign raw[CH_LSLANT] = sample.left_slant_sample;
  assign raw[CH_RSLANT] = sample.right_slant_sample;

  assign out_adv      = !result.valid || result.ready;
  assign sample.ready = !s1_valid || out_adv;
  assign take         = sample.valid && sample.ready;

  assign cell_d[0] = raw;
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      cell_sum[0][c] = SUM_W'(raw[c]);
    end
  end

  for (genvar i = 0; i < PAST_TAPS; i++) begin : g_tap
    itfss_tap_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (take),
      .din     (cell_d[i]),
      .sum_in  (cell_sum[i]),
      .dout    (cell_d[i+1]),
      .sum_out (cell_sum[i+1])
    );
  end

  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int c = 0; c < CHANNELS; c++) begin
      prod         = PROD_W'(cell_sum[PAST_TAPS][c]) * PROD_W'(DIV_MUL);
      filt_next[c] = prod[DIV_SHIFT +: SAMPLE_W];
    end
  end

  itfss_select u_select (
    .filt  (filt),
    .steer (steer)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (out_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && out_adv) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      filt <= filt_next;
    end
    if (s1_valid && out_adv) begin
      result.steer_target     <= steer.steer_target;
      result.right_wheel_duty <= steer.right_wheel_duty;
      result.left_wheel_duty  <= steer.left_wheel_duty;
      result.gain_prop        <= steer.gain_prop;
      result.gain_deriv       <= steer.gain_deriv;
      result.filt_vertical    <= filt[CH_VERT];
      result.filt_left_level  <= filt[CH_LEFT];
      result.filt_right_level <= filt[CH_RIGHT];
      result.filt_left_slant  <= filt[CH_LSLANT];
      result.filt_right_slant <= filt[CH_RSLANT];
    end
  end

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.steer_target >= -8'sd15 && result.steer_target <= 8'sd75))
    else $error("steer target out of range");

  a_cross_gains: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.gain_prop == 2'd1) == (result.gain_deriv == 8'd50)))
    else $error("crossing gains inconsistent");

  a_both_high: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.gain_deriv == 8'd30 |->
      result.right_wheel_duty == 9'd300 && result.left_wheel_duty == 9'd300)
    else $error("both-high duties wrong");

  a_tap_shift: assert property (@(posedge clk) disable iff (rst)
    take |=> cell_d[1][CH_VERT] == $past(sample.vertical_sample))
    else $error("history did not shift in accepted item");

  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    take |=> s1_valid)
    else $error("accepted item lost before selection stage");

endmodule

[verif/inductor_track_filter_and_steer_select_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inductor_track_filter_and_steer_select_unit_tb
// Self-checking bench for the inductor filter and steering case select.
// ----------------------------------------------------------------------------
// Drives five-channel sample items through the input channel and predicts each
// result with a seven-tap moving average and case decision kept in the bench.
// A short table covers reset history, saturated inputs and the curve and
// crossing cases. Random track scenarios follow: each pattern is held for
// several ticks with jitter, so the filtered values settle into every case.
// The sender works in bursts with gaps and the receiver stalls in patterns.
// Every result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module inductor_track_filter_and_steer_select_unit_tb;
  import itfss_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_MAX   = 10;
  localparam int DIR_ROWS     = 6;

  typedef struct packed {
    steer_t    steer;
    chan_vec_t filt;
  } track_result_t;

  typedef struct {
    chan_vec_t     raw;
    int            hold;
    bit            typed;
    track_result_t result;
  } dir_row_t;

  typedef enum {SC_STRAIGHT, SC_LEFT, SC_RIGHT, SC_CROSS, SC_BOTH_HIGH, SC_NOISE} track_case_e;
  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_THIRD} rx_mode_e;

  logic clk;
  logic rst;

  itfss_in_if  sample_if ();
  itfss_out_if result_if ();

  inductor_track_filter_and_steer_select_unit dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if.sink),
    .result (result_if.source)
  );

  logic [7:0]    tap_history [CHANNELS][PAST_TAPS];
  track_result_t expected_q [$];
  bit            typed_flag;
  track_result_t typed_result;
  int            error_count;
  int            cycle_count;
  int            burst_left;
  rx_mode_e      rx_mode;
  int            rx_phase;
  int            rx_tick;
  dir_row_t      dir_rows [DIR_ROWS];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic chan_vec_t mk_chan(int v, int l, int r, int sl, int sr);
    chan_vec_t ch;
    ch[CH_VERT]   = v[7:0];
    ch[CH_LEFT]   = l[7:0];
    ch[CH_RIGHT]  = r[7:0];
    ch[CH_LSLANT] = sl[7:0];
    ch[CH_RSLANT] = sr[7:0];
    return ch;
  endfunction

  function automatic steer_t mk_steer(int target, int rd, int ld, int gp, int gd);
    steer_t st;
    st.steer_target     = target[7:0];
    st.right_wheel_duty = rd[8:0];
    st.left_wheel_duty  = ld[8:0];
    st.gain_prop        = gp[1:0];
    st.gain_deriv       = gd[7:0];
    return st;
  endfunction

  function automatic logic [7:0] byte_near(int mid, int spread);
    int v;
    v = mid + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // advance the history and work out the steering decision for one tick
  function automatic track_result_t predict_track(chan_vec_t raw);
    track_result_t res;
    int            filt [CHANNELS];
    int            acc;
    int            v, l, r, sl, sr, diff, lr_sum, clamped;
    int            target, rduty, lduty, gp, gd;
    for (int c = 0; c < CHANNELS; c++) begin
      acc = raw[c];
      for (int k = 0; k < PAST_TAPS; k++) acc += tap_history[c][k];
      for (int k = PAST_TAPS - 1; k > 0; k--) tap_history[c][k] = tap_history[c][k-1];
      tap_history[c][0] = raw[c];
      filt[c] = acc / HISTORY_DEPTH;
    end
    v      = filt[CH_VERT];
    l      = filt[CH_LEFT];
    r      = filt[CH_RIGHT];
    sl     = filt[CH_LSLANT];
    sr     = filt[CH_RSLANT];
    diff   = sl - sr;
    lr_sum = l + r;
    target = 30 + diff / 8;
    rduty  = 320;
    lduty  = 320;
    gp     = 3;
    gd     = 0;
    if (l > 110 && r > 110) begin
      gp    = 2;
      gd    = 30;
      rduty = 300;
      lduty = 300;
    end else if (sr < 50 && sl > sr) begin
      target = 75 - sl / 10;
      rduty  = 270;
      if (sr < 10 && lr_sum < 150) rduty = 240;
      if (sr < 5 && lr_sum < 150) rduty = 220;
      lduty = rduty - 50;
      gd    = 250;
    end else if (sl < 50 && sr > sl) begin
      target = sr / 10 - 15;
      lduty  = 270;
      if (sl < 20 && lr_sum < 130) lduty = 240;
      if (sl < 5 && lr_sum < 130) lduty = 220;
      rduty = lduty - 50;
      gd    = 250;
    end else begin
      gp = 3;
      gd = 250;
    end
    if (v > 190) begin
      clamped = diff;
      if (clamped > 100) clamped = 100;
      if (clamped < -100) clamped = -100;
      gp     = 1;
      gd     = 50;
      target = 30 + clamped / 8;
    end
    res.steer = mk_steer(target, rduty, lduty, gp, gd);
    for (int c = 0; c < CHANNELS; c++) res.filt[c] = filt[c][7:0];
    return res;
  endfunction

  function automatic void check_field(string name, int expv, int actv);
    if (expv != actv) begin
      error_count++;
      if (error_count <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, expv, actv);
    end
  endfunction

  always @(posedge clk) begin
    track_result_t predicted;
    track_result_t want;
    chan_vec_t     raw;
    if (!rst) begin
      if (sample_if.valid && sample_if.ready) begin
        raw = mk_chan(sample_if.vertical_sample, sample_if.left_level_sample,
                      sample_if.right_level_sample, sample_if.left_slant_sample,
                      sample_if.right_slant_sample);
        predicted = predict_track(raw);
        expected_q.push_back(typed_flag ? typed_result : predicted);
      end
      if (result_if.valid && result_if.ready) begin
        if (expected_q.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("%0t: result item with no prediction waiting", $realtime);
        end else begin
          want = expected_q.pop_front();
          check_field("steer_target", $signed(want.steer.steer_target),
                      $signed(result_if.steer_target));
          check_field("right_wheel_duty", want.steer.right_wheel_duty,
                      result_if.right_wheel_duty);
          check_field("left_wheel_duty", want.steer.left_wheel_duty,
                      result_if.left_wheel_duty);
          check_field("gain_prop", want.steer.gain_prop, result_if.gain_prop);
          check_field("gain_deriv", want.steer.gain_deriv, result_if.gain_deriv);
          check_field("filt_vertical", want.filt[CH_VERT], result_if.filt_vertical);
          check_field("filt_left_level", want.filt[CH_LEFT], result_if.filt_left_level);
          check_field("filt_right_level", want.filt[CH_RIGHT], result_if.filt_right_level);
          check_field("filt_left_slant", want.filt[CH_LSLANT], result_if.filt_left_slant);
          check_field("filt_right_slant", want.filt[CH_RSLANT], result_if.filt_right_slant);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[inductor_track_filter_and_steer_select_unit] ERROR");
      $finish;
    end
  end

  // receiver stall pattern, changing mode whenever its random phase count runs out
  always @(negedge clk) begin
    if (rx_phase == 0) begin
      rx_mode  <= rx_mode_e'($urandom_range(0, 3));
      rx_phase <= $urandom_range(20, 80);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_OPEN:   result_if.ready <= 1'b1;
      RX_MOSTLY: result_if.ready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: result_if.ready <= ($urandom_range(0, 3) == 0);
      default:   result_if.ready <= (rx_tick % 3 == 0);
    endcase
  end

  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        sample_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic send_sample(chan_vec_t raw, bit typed, track_result_t typed_val);
    @(negedge clk);
    sample_if.valid              <= 1'b1;
    sample_if.vertical_sample    <= raw[CH_VERT];
    sample_if.left_level_sample  <= raw[CH_LEFT];
    sample_if.right_level_sample <= raw[CH_RIGHT];
    sample_if.left_slant_sample  <= raw[CH_LSLANT];
    sample_if.right_slant_sample <= raw[CH_RSLANT];
    typed_flag                   <= typed;
    typed_result                 <= typed_val;
    do @(posedge clk); while (!sample_if.ready);
    pace_sender();
  endtask

  initial begin
    track_case_e   sc;
    chan_vec_t     mid;
    chan_vec_t     raw;
    track_result_t none;
    int            hold;
    int            spread;
    int            sent;
    rst                          = 1'b1;
    sample_if.valid              = 1'b0;
    sample_if.vertical_sample    = '0;
    sample_if.left_level_sample  = '0;
    sample_if.right_level_sample = '0;
    sample_if.left_slant_sample  = '0;
    sample_if.right_slant_sample = '0;
    result_if.ready              = 1'b0;
    typed_flag                   = 1'b0;
    typed_result                 = '0;
    none                         = '0;
    error_count                  = 0;
    cycle_count                  = 0;
    rx_mode                      = RX_OPEN;
    rx_phase                     = 0;
    rx_tick                      = 0;
    burst_left                   = $urandom_range(1, 40);
    for (int c = 0; c < CHANNELS; c++)
      for (int k = 0; k < PAST_TAPS; k++) tap_history[c][k] = '0;

    // empty history, first full-scale tick, settled full scale with crossing,
    // hard left curve under crossing, hard right curve, near-zero slants
    dir_rows[0] = '{mk_chan(0, 0, 0, 0, 0), 1, 1'b1,
                    '{mk_steer(30, 320, 320, 3, 250), mk_chan(0, 0, 0, 0, 0)}};
    dir_rows[1] = '{mk_chan(255, 255, 255, 255, 255), 1, 1'b1,
                    '{mk_steer(30, 320, 320, 3, 250), mk_chan(36, 36, 36, 36, 36)}};
    dir_rows[2] = '{mk_chan(255, 255, 255, 255, 255), 6, 1'b1,
                    '{mk_steer(30, 300, 300, 1, 50), mk_chan(255, 255, 255, 255, 255)}};
    dir_rows[3] = '{mk_chan(255, 0, 0, 255, 0), 7, 1'b1,
                    '{mk_steer(42, 220, 170, 1, 50), mk_chan(255, 0, 0, 255, 0)}};
    dir_rows[4] = '{mk_chan(0, 0, 0, 0, 255), 7, 1'b0, none};
    dir_rows[5] = '{mk_chan(0, 128, 0, 3, 1), 2, 1'b0, none};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      for (int n = 0; n < dir_rows[i].hold; n++)
        send_sample(dir_rows[i].raw, dir_rows[i].typed && (n == dir_rows[i].hold - 1),
                    dir_rows[i].result);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1:    sc = SC_STRAIGHT;
        2, 3:    sc = SC_LEFT;
        4, 5:    sc = SC_RIGHT;
        6, 7:    sc = SC_CROSS;
        8:       sc = SC_BOTH_HIGH;
        default: sc = SC_NOISE;
      endcase
      mid[CH_VERT]   = 8'($urandom_range(0, 190));
      mid[CH_LEFT]   = 8'($urandom_range(0, 140));
      mid[CH_RIGHT]  = 8'($urandom_range(0, 140));
      mid[CH_LSLANT] = 8'($urandom_range(40, 220));
      mid[CH_RSLANT] = 8'($urandom_range(40, 220));
      case (sc)
        SC_LEFT: begin
          mid[CH_LSLANT] = 8'($urandom_range(30, 255));
          mid[CH_RSLANT] = 8'($urandom_range(0, ($urandom_range(0, 1) != 0) ? 12 : 55));
        end
        SC_RIGHT: begin
          mid[CH_RSLANT] = 8'($urandom_range(30, 255));
          mid[CH_LSLANT] = 8'($urandom_range(0, ($urandom_range(0, 1) != 0) ? 25 : 55));
        end
        SC_CROSS: begin
          mid[CH_VERT]   = 8'($urandom_range(185, 255));
          mid[CH_LEFT]   = 8'($urandom_range(0, 255));
          mid[CH_RIGHT]  = 8'($urandom_range(0, 255));
          mid[CH_LSLANT] = 8'($urandom_range(0, 255));
          mid[CH_RSLANT] = 8'($urandom_range(0, 255));
        end
        SC_BOTH_HIGH: begin
          mid[CH_LEFT]  = 8'($urandom_range(100, 255));
          mid[CH_RIGHT] = 8'($urandom_range(100, 255));
        end
        default: ;
      endcase
      hold   = (sc == SC_NOISE) ? $urandom_range(1, 6) : $urandom_range(3, 14);
      spread = $urandom_range(0, 6);
      for (int n = 0; n < hold; n++) begin
        for (int c = 0; c < CHANNELS; c++)
          raw[c] = (sc == SC_NOISE) ? 8'($urandom_range(0, 255)) : byte_near(mid[c], spread);
        send_sample(raw, 1'b0, none);
        sent++;
      end
    end

    @(negedge clk);
    sample_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("[inductor_track_filter_and_steer_select_unit] OK");
    else
      $display("[inductor_track_filter_and_steer_select_unit] ERROR");
    $finish;
  end

endmodule
